// ----- rtl/core/vel_pkg.sv -----
`default_nettype none
package vel_pkg;

    localparam int COORD_WIDTH_DEF = 13;
    localparam int LEN_W           = 7;
    localparam int Q_W             = 7;
    localparam int SCALE_W         = 5;
    localparam int CFG_IDX_W       = 2;

    localparam logic [CFG_IDX_W-1:0] REG_CENTER_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y = 2'd1;

    localparam logic [LEN_W-1:0] LEN_0 = 7'd25;
    localparam logic [LEN_W-1:0] LEN_1 = 7'd37;
    localparam logic [LEN_W-1:0] LEN_2 = 7'd49;
    localparam logic [LEN_W-1:0] LEN_3 = 7'd61;
    localparam logic [LEN_W-1:0] LEN_4 = 7'd73;

    localparam logic [SCALE_W-1:0] SCALE_LIM_0 = 5'd5;
    localparam logic [SCALE_W-1:0] SCALE_LIM_1 = 5'd10;
    localparam logic [SCALE_W-1:0] SCALE_LIM_2 = 5'd15;
    localparam logic [SCALE_W-1:0] SCALE_LIM_3 = 5'd20;

    function automatic logic [LEN_W-1:0] target_length(input logic [SCALE_W-1:0] scale);
        logic [LEN_W-1:0] len;
        if (scale <= SCALE_LIM_0)
            len = LEN_0;
        else if (scale <= SCALE_LIM_1)
            len = LEN_1;
        else if (scale <= SCALE_LIM_2)
            len = LEN_2;
        else if (scale <= SCALE_LIM_3)
            len = LEN_3;
        else
            len = LEN_4;
        return len;
    endfunction

endpackage
`default_nettype wire

// ----- rtl/core/vel_ifs.sv -----
`default_nettype none
interface vel_in_if #(parameter int W = 13);
    logic         valid;
    logic         ready;
    logic [W-1:0] end_x;
    logic [W-1:0] end_y;
    logic [4:0]   range_scale;

    modport source (output valid, end_x, end_y, range_scale, input ready);
    modport sink (input valid, end_x, end_y, range_scale, output ready);
endinterface

interface vel_out_if #(parameter int W = 13);
    logic         valid;
    logic         ready;
    logic [W-1:0] new_x;
    logic [W-1:0] new_y;
    logic         degenerate;

    modport source (output valid, new_x, new_y, degenerate, input ready);
    modport sink (input valid, new_x, new_y, degenerate, output ready);
endinterface
`default_nettype wire

// ----- rtl/core/vel_sqrt_cell.sv -----
`default_nettype none
module vel_sqrt_cell #(
    parameter int R      = 14,
    parameter int K      = 0,
    parameter int SIDE_W = 1
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              en,
    input  wire logic              valid_in,
    input  wire logic [2*R-1:0]    sq_in,
    input  wire logic [R+1:0]      rem_in,
    input  wire logic [R-1:0]      root_in,
    input  wire logic [SIDE_W-1:0] side_in,
    output logic                   valid_out,
    output logic [2*R-1:0]         sq_out,
    output logic [R+1:0]           rem_out,
    output logic [R-1:0]           root_out,
    output logic [SIDE_W-1:0]      side_out
);
    logic [R+2:0]  rem_sh;
    logic [R+2:0]  trial;
    logic          take;
    logic [R+1:0]  rem_next;
    logic [R-1:0]  root_next;

    // bring down the next bit pair and try the next root bit;
    // the remainder never exceeds twice the partial root, so its top bit is zero
    always_comb
    begin
        rem_sh = {rem_in[R:0], sq_in[2*K+1 -: 2]};
        trial  = {1'b0, root_in, 2'b01};
        take   = (rem_sh >= trial);
        if (take)
        begin
            rem_next  = (R+2)'(rem_sh - trial);
            root_next = {root_in[R-2:0], 1'b1};
        end
        else
        begin
            rem_next  = rem_sh[R+1:0];
            root_next = {root_in[R-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_out <= 1'b0;
        else if (en)
            valid_out <= valid_in;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sq_out   <= sq_in;
            rem_out  <= rem_next;
            root_out <= root_next;
            side_out <= side_in;
        end
    end
endmodule
`default_nettype wire

// ----- rtl/core/vel_div_cell.sv -----
`default_nettype none
module vel_div_cell #(
    parameter int NW     = 22,
    parameter int DVW    = 15,
    parameter int SHIFT  = 0,
    parameter int SIDE_W = 1
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              en,
    input  wire logic              valid_in,
    input  wire logic [NW-1:0]     rem_x_in,
    input  wire logic [NW-1:0]     rem_y_in,
    input  wire logic [DVW-1:0]    div_in,
    input  wire logic [vel_pkg::Q_W-1:0] q_x_in,
    input  wire logic [vel_pkg::Q_W-1:0] q_y_in,
    input  wire logic [SIDE_W-1:0] side_in,
    output logic                   valid_out,
    output logic [NW-1:0]          rem_x_out,
    output logic [NW-1:0]          rem_y_out,
    output logic [DVW-1:0]         div_out,
    output logic [vel_pkg::Q_W-1:0] q_x_out,
    output logic [vel_pkg::Q_W-1:0] q_y_out,
    output logic [SIDE_W-1:0]      side_out
);
    import vel_pkg::*;

    logic [NW-1:0] dsh;
    logic          take_x;
    logic          take_y;

    // one restoring quotient bit per lane
    always_comb
    begin
        dsh    = NW'(div_in) << SHIFT;
        take_x = (rem_x_in >= dsh);
        take_y = (rem_y_in >= dsh);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_out <= 1'b0;
        else if (en)
            valid_out <= valid_in;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_x_out <= take_x ? rem_x_in - dsh : rem_x_in;
            rem_y_out <= take_y ? rem_y_in - dsh : rem_y_in;
            q_x_out   <= {q_x_in[Q_W-2:0], take_x};
            q_y_out   <= {q_y_in[Q_W-2:0], take_y};
            div_out   <= div_in;
            side_out  <= side_in;
        end
    end
endmodule
`default_nettype wire

// ----- rtl/core/vector_endpoint_length_clamp_top.sv -----
`default_nettype none
// Throughput: one beat per cycle; the whole pipeline advances together and
// stalls only while the output register holds a beat the sink has not taken.
// The chain is three front stages, one square-root cell per root bit, one
// numerator stage, seven divider cells and the output register.
// Reset (rst_n, asynchronous, active low) clears all valid bits and both centers.
module vector_endpoint_length_clamp_top #(
    parameter int COORD_WIDTH = vel_pkg::COORD_WIDTH_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    vel_in_if.sink                             ep_in,
    vel_out_if.source                          ep_out,
    input  wire logic                          cfg_we,
    input  wire logic [vel_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [COORD_WIDTH-2:0]        cfg_data
);
    import vel_pkg::*;

    localparam int W      = COORD_WIDTH;
    localparam int R      = W + 1;          // root bits
    localparam int NW     = W + 9;          // numerator width
    localparam int DVW    = R + 1;          // 2*root width
    localparam int SIDE_W = 2*W + 2 + LEN_W + 1;
    localparam int DS_W   = 3;
    localparam int NDIV   = Q_W;

    // ---------------- configuration ----------------
    logic [W-2:0] center_x_reg;
    logic [W-2:0] center_y_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_x_reg <= '0;
            center_y_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_CENTER_X: center_x_reg <= cfg_data;
                REG_CENTER_Y: center_y_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Every stage moves on the same enable; hold all of them while the
    // output beat waits.
    logic out_valid_reg;
    logic en;

    assign en          = !out_valid_reg || ep_out.ready;
    assign ep_in.ready = en;

    // ---------------- stage A: offsets and magnitudes ----------------
    logic signed [W:0] dx_s;
    logic signed [W:0] dy_s;
    logic [W:0]        ndx;
    logic [W:0]        ndy;

    assign dx_s = $signed({ep_in.end_x[W-1], ep_in.end_x}) - $signed({2'b00, center_x_reg});
    assign dy_s = $signed({ep_in.end_y[W-1], ep_in.end_y}) - $signed({2'b00, center_y_reg});
    assign ndx  = -dx_s;
    assign ndy  = -dy_s;

    logic             a_valid_reg;
    logic [W-1:0]     a_magx_reg;
    logic [W-1:0]     a_magy_reg;
    logic             a_sx_reg;
    logic             a_sy_reg;
    logic [LEN_W-1:0] a_len_reg;
    logic             a_degen_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            a_valid_reg <= 1'b0;
        else if (en)
            a_valid_reg <= ep_in.valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_magx_reg  <= dx_s[W] ? ndx[W-1:0] : dx_s[W-1:0];
            a_magy_reg  <= dy_s[W] ? ndy[W-1:0] : dy_s[W-1:0];
            a_sx_reg    <= dx_s[W];
            a_sy_reg    <= dy_s[W];
            a_len_reg   <= target_length(ep_in.range_scale);
            a_degen_reg <= (dx_s == '0) && (dy_s == '0);
        end
    end

    logic [SIDE_W-1:0] a_side;
    assign a_side = {a_magx_reg, a_magy_reg, a_sx_reg, a_sy_reg, a_len_reg, a_degen_reg};

    // ---------------- stage B: squares ----------------
    logic              b_valid_reg;
    logic [2*W-1:0]    b_sqx_reg;
    logic [2*W-1:0]    b_sqy_reg;
    logic [SIDE_W-1:0] b_side_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            b_valid_reg <= 1'b0;
        else if (en)
            b_valid_reg <= a_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            b_sqx_reg  <= a_magx_reg * a_magx_reg;
            b_sqy_reg  <= a_magy_reg * a_magy_reg;
            b_side_reg <= a_side;
        end
    end

    // ---------------- stage C: sum of squares ----------------
    logic              c_valid_reg;
    logic [2*R-1:0]    c_sq_reg;
    logic [SIDE_W-1:0] c_side_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            c_valid_reg <= 1'b0;
        else if (en)
            c_valid_reg <= b_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c_sq_reg   <= (2*R)'(b_sqx_reg) + (2*R)'(b_sqy_reg);
            c_side_reg <= b_side_reg;
        end
    end

    // ---------------- square-root chain: one root bit per cell ----------------
    logic              s_valid [0:R];
    logic [2*R-1:0]    s_sq    [0:R];
    logic [R+1:0]      s_rem   [0:R];
    logic [R-1:0]      s_root  [0:R];
    logic [SIDE_W-1:0] s_side  [0:R];

    assign s_valid[0] = c_valid_reg;
    assign s_sq[0]    = c_sq_reg;
    assign s_rem[0]   = '0;
    assign s_root[0]  = '0;
    assign s_side[0]  = c_side_reg;

    for (genvar i = 0; i < R; i++)
    begin : g_sqrt
        vel_sqrt_cell #(
            .R      (R),
            .K      (R - 1 - i),
            .SIDE_W (SIDE_W)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .valid_in  (s_valid[i]),
            .sq_in     (s_sq[i]),
            .rem_in    (s_rem[i]),
            .root_in   (s_root[i]),
            .side_in   (s_side[i]),
            .valid_out (s_valid[i+1]),
            .sq_out    (s_sq[i+1]),
            .rem_out   (s_rem[i+1]),
            .root_out  (s_root[i+1]),
            .side_out  (s_side[i+1])
        );
    end

    // ---------------- numerator stage: 2*len*|d| + root ----------------
    logic [W-1:0]     n_magx;
    logic [W-1:0]     n_magy;
    logic             n_sx;
    logic             n_sy;
    logic [LEN_W-1:0] n_len;
    logic             n_degen;
    logic [R-1:0]     root_dist;

    assign {n_magx, n_magy, n_sx, n_sy, n_len, n_degen} = s_side[R];
    assign root_dist = s_root[R];

    logic              n_valid_reg;
    logic [NW-1:0]     n_remx_reg;
    logic [NW-1:0]     n_remy_reg;
    logic [DVW-1:0]    n_div_reg;
    logic [DS_W-1:0]   n_side_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            n_valid_reg <= 1'b0;
        else if (en)
            n_valid_reg <= s_valid[R];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            n_remx_reg <= ((NW'(n_len) * NW'(n_magx)) << 1) + NW'(root_dist);
            n_remy_reg <= ((NW'(n_len) * NW'(n_magy)) << 1) + NW'(root_dist);
            n_div_reg  <= {root_dist, 1'b0};
            n_side_reg <= {n_sx, n_sy, n_degen};
        end
    end

    // ---------------- divider chain: one quotient bit per cell ----------------
    logic             d_valid [0:NDIV];
    logic [NW-1:0]    d_remx  [0:NDIV];
    logic [NW-1:0]    d_remy  [0:NDIV];
    logic [DVW-1:0]   d_div   [0:NDIV];
    logic [Q_W-1:0]   d_qx    [0:NDIV];
    logic [Q_W-1:0]   d_qy    [0:NDIV];
    logic [DS_W-1:0]  d_side  [0:NDIV];

    assign d_valid[0] = n_valid_reg;
    assign d_remx[0]  = n_remx_reg;
    assign d_remy[0]  = n_remy_reg;
    assign d_div[0]   = n_div_reg;
    assign d_qx[0]    = '0;
    assign d_qy[0]    = '0;
    assign d_side[0]  = n_side_reg;

    for (genvar j = 0; j < NDIV; j++)
    begin : g_div
        vel_div_cell #(
            .NW     (NW),
            .DVW    (DVW),
            .SHIFT  (NDIV - 1 - j),
            .SIDE_W (DS_W)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .valid_in  (d_valid[j]),
            .rem_x_in  (d_remx[j]),
            .rem_y_in  (d_remy[j]),
            .div_in    (d_div[j]),
            .q_x_in    (d_qx[j]),
            .q_y_in    (d_qy[j]),
            .side_in   (d_side[j]),
            .valid_out (d_valid[j+1]),
            .rem_x_out (d_remx[j+1]),
            .rem_y_out (d_remy[j+1]),
            .div_out   (d_div[j+1]),
            .q_x_out   (d_qx[j+1]),
            .q_y_out   (d_qy[j+1]),
            .side_out  (d_side[j+1])
        );
    end

    // ---------------- output stage: apply sign, add center, saturate ----------------
    localparam logic signed [W+1:0] SAT_MAX = (W+2)'((1 << (W-1)) - 1);
    localparam logic signed [W+1:0] SAT_MIN = -(W+2)'(1 << (W-1));

    logic              f_sx;
    logic              f_sy;
    logic              f_degen;
    logic signed [W+1:0] offx;
    logic signed [W+1:0] offy;
    logic signed [W+1:0] sumx;
    logic signed [W+1:0] sumy;
    logic [W-1:0]      satx;
    logic [W-1:0]      saty;

    assign {f_sx, f_sy, f_degen} = d_side[NDIV];

    always_comb
    begin
        offx = f_sx ? -$signed((W+2)'(d_qx[NDIV])) : $signed((W+2)'(d_qx[NDIV]));
        offy = f_sy ? -$signed((W+2)'(d_qy[NDIV])) : $signed((W+2)'(d_qy[NDIV]));
        sumx = $signed({3'b000, center_x_reg}) + offx;
        sumy = $signed({3'b000, center_y_reg}) + offy;
        if (sumx > SAT_MAX)
            satx = SAT_MAX[W-1:0];
        else if (sumx < SAT_MIN)
            satx = SAT_MIN[W-1:0];
        else
            satx = sumx[W-1:0];
        if (sumy > SAT_MAX)
            saty = SAT_MAX[W-1:0];
        else if (sumy < SAT_MIN)
            saty = SAT_MIN[W-1:0];
        else
            saty = sumy[W-1:0];
    end

    logic [W-1:0] new_x_reg;
    logic [W-1:0] new_y_reg;
    logic         degen_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (en)
            out_valid_reg <= d_valid[NDIV];
    end

    // Return the center itself when the endpoint sits on it.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            new_x_reg <= f_degen ? {1'b0, center_x_reg} : satx;
            new_y_reg <= f_degen ? {1'b0, center_y_reg} : saty;
            degen_reg <= f_degen;
        end
    end

    assign ep_out.valid      = out_valid_reg;
    assign ep_out.new_x      = new_x_reg;
    assign ep_out.new_y      = new_y_reg;
    assign ep_out.degenerate = degen_reg;
endmodule
`default_nettype wire
